### rtl/cfe_pkg.sv
// Shared constants, CRC-16 byte update and item type for the command frame encoder.
`timescale 1ns / 1ps

package cfe_pkg;

  localparam logic [7:0] START_BYTE = 8'h0C;

  localparam logic [7:0] FUNC_VALVE  = 8'h0A;
  localparam logic [7:0] FUNC_ENGINE = 8'h0B;
  localparam logic [7:0] FUNC_RESET  = 8'h0C;

  localparam logic [7:0] DEV_VALVE_A = 8'd1;
  localparam logic [7:0] DEV_VALVE_B = 8'd2;
  localparam logic [7:0] DEV_VALVE_C = 8'd3;
  localparam logic [7:0] DEV_ENGINE  = 8'd4;
  localparam logic [7:0] DEV_RESET   = 8'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int FRAME_LEN = 6;
  localparam int FRAME_W   = 8 * FRAME_LEN;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  // CRC-16/MODBUS, one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Check word after the start byte and each possible function code
  localparam logic [15:0] CRC_START  = crc_byte(CRC_INIT, START_BYTE);
  localparam logic [15:0] CRC_VALVE  = crc_byte(CRC_START, FUNC_VALVE);
  localparam logic [15:0] CRC_ENGINE = crc_byte(CRC_START, FUNC_ENGINE);
  localparam logic [15:0] CRC_RESET  = crc_byte(CRC_START, FUNC_RESET);

  typedef struct packed {
    logic [7:0]  dev;
    logic [7:0]  func;
    logic [7:0]  val;
    logic [15:0] crc;
  } cfe_item_t;

endpackage

### rtl/command_frame_encoder_crc16_unit.sv
// Top level of the command frame encoder with CRC-16/MODBUS check word.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+-------------------------------
//  in      | in_valid_i | in_stall_o | device_id_i, command_value_i
//  out     | out_valid_o| out_stall_i| frame_byte_o, last_byte_o
//
// A known command yields six output items on consecutive free cycles of
// the out channel; the frame register reloads as its last byte is taken.
// The input register holds one further command while a frame is being sent.
// First byte is out after the input and frame registers; unknown device ids
// are accepted and produce nothing. Reset clears the valid flags and byte count.
// Stalls on the out channel hold the current byte and back up into in_stall_o.
`timescale 1ns / 1ps

module command_frame_encoder_crc16_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] device_id_i,
  input  logic [7:0] command_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o
);
  import cfe_pkg::*;

  logic      item_valid;
  logic      take;
  cfe_item_t item;

  cfe_in_stage u_in_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .device_id_i     (device_id_i),
    .command_value_i (command_value_i),
    .take_i          (take),
    .item_valid_o    (item_valid),
    .item_o          (item)
  );

  cfe_frame_ser u_frame_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

### rtl/cfe_in_stage.sv
// Input register: device decode, function code and check word up to the device id.
`timescale 1ns / 1ps

module cfe_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       device_id_i,
  input  logic [7:0]       command_value_i,
  input  logic             take_i,
  output logic             item_valid_o,
  output cfe_pkg::cfe_item_t item_o
);
  import cfe_pkg::*;

  logic        valid_q;
  cfe_item_t   item_q;
  logic        accept;
  logic        known;
  logic [7:0]  func;
  logic [15:0] crc_func;

  always_comb begin
    known    = 1'b1;
    func     = FUNC_VALVE;
    crc_func = CRC_VALVE;
    case (device_id_i)
      DEV_VALVE_A, DEV_VALVE_B, DEV_VALVE_C: begin
        func     = FUNC_VALVE;
        crc_func = CRC_VALVE;
      end
      DEV_ENGINE: begin
        func     = FUNC_ENGINE;
        crc_func = CRC_ENGINE;
      end
      DEV_RESET: begin
        func     = FUNC_RESET;
        crc_func = CRC_RESET;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Unknown devices are accepted and dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= known;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && known) begin
      item_q.dev  <= device_id_i;
      item_q.func <= func;
      item_q.val  <= command_value_i;
      item_q.crc  <= crc_byte(crc_func, device_id_i);
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### rtl/cfe_frame_ser.sv
// Frame register: final check word update and byte-wise shift-out of the frame.
`timescale 1ns / 1ps

module cfe_frame_ser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  cfe_pkg::cfe_item_t item_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         frame_byte_o,
  output logic               last_byte_o
);
  import cfe_pkg::*;

  logic               valid_q;
  logic [IDX_W-1:0]   cnt_q;
  logic [FRAME_W-1:0] shift_q;
  logic [15:0]        crc_fin;
  logic               fire;
  logic               at_last;
  logic               free;

  assign crc_fin = crc_byte(item_i.crc, item_i.val);
  assign fire    = valid_q && !out_stall_i;
  assign at_last = (cnt_q == LAST_IDX);
  assign free    = !valid_q || (fire && at_last);
  assign take_o  = item_valid_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (take_o) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (fire) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Load the whole frame, then advance one byte per taken item
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      shift_q <= {START_BYTE, item_i.func, item_i.dev, item_i.val, crc_fin[15:8], crc_fin[7:0]};
    end else if (fire && !at_last) begin
      shift_q <= {shift_q[FRAME_W-9:0], 8'h00};
    end
  end

  assign out_valid_o  = valid_q;
  assign frame_byte_o = shift_q[FRAME_W-1 -: 8];
  assign last_byte_o  = valid_q && at_last;

endmodule

### rtl/cfe_checker.sv
// Port-level checker for the command frame encoder, bound to the top level.
`timescale 1ns / 1ps

module cfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] frame_byte_o,
  input logic       last_byte_o
);
  import cfe_pkg::*;

  logic mid_q;

  // Track whether the next out item lies inside a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      mid_q <= !last_byte_o;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(frame_byte_o) && $stable(last_byte_o))
    else $error("stalled out item changed");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mid_q |-> frame_byte_o == START_BYTE)
    else $error("frame does not open with the start byte");

  a_frame_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_byte_o |=> out_valid_o)
    else $error("gap inside a frame");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output is idle");

endmodule

bind command_frame_encoder_crc16_unit cfe_checker u_cfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o)
);

### tb/sv/cfe_frame_checker.sv
// Frame checker: predicts each command frame and compares the output bytes against it.
`timescale 1ns / 1ps

module cfe_frame_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] device_id_i,
  input  logic [7:0] command_value_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] frame_byte_i,
  input  logic       last_byte_i,
  output int         err_count_o,
  output int         pending_o
);
  import cfe_pkg::*;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];

  initial begin
    err_count_o = 0;
    pending_o   = 0;
  end

  // bitwise form: feed one data bit per shift, LSB first
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc;
    for (int k = 0; k < 8; k++) begin
      if (acc[0] ^ b[k]) acc = {1'b0, acc[15:1]} ^ CRC_POLY;
      else acc = {1'b0, acc[15:1]};
    end
    return acc;
  endfunction

  function automatic void queue_frame(input logic [7:0] dev, input logic [7:0] val);
    logic [7:0]  func;
    logic [7:0]  frame [FRAME_LEN];
    logic [15:0] crc;
    frame_byte_t item;
    case (dev)
      DEV_VALVE_A, DEV_VALVE_B, DEV_VALVE_C: func = FUNC_VALVE;
      DEV_ENGINE: func = FUNC_ENGINE;
      DEV_RESET: func = FUNC_RESET;
      default: return; // unknown device: drop the command silently
    endcase
    frame[0] = START_BYTE;
    frame[1] = func;
    frame[2] = dev;
    frame[3] = val;
    crc = CRC_INIT;
    for (int i = 0; i < 4; i++) crc = modbus_crc_step(crc, frame[i]);
    frame[4] = crc[15:8];
    frame[5] = crc[7:0];
    for (int i = 0; i < FRAME_LEN; i++) begin
      item.data = frame[i];
      item.last = (i == FRAME_LEN - 1);
      expected_bytes.push_back(item);
    end
  endfunction

  always @(posedge clk_i) begin
    frame_byte_t exp_item;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          if (err_count_o < REPORT_MAX)
            $display("%0t: unexpected output item byte=%02h last=%b",
                     $realtime, frame_byte_i, last_byte_i);
          err_count_o = err_count_o + 1;
        end else begin
          exp_item = expected_bytes.pop_front();
          if (frame_byte_i !== exp_item.data || last_byte_i !== exp_item.last) begin
            if (err_count_o < REPORT_MAX)
              $display("%0t: output mismatch: expected byte=%02h last=%b, got byte=%02h last=%b",
                       $realtime, exp_item.data, exp_item.last, frame_byte_i, last_byte_i);
            err_count_o = err_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) queue_frame(device_id_i, command_value_i);
      pending_o = expected_bytes.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top: drives commands and output stalls, and gives the verdict for the frame encoder.
`timescale 1ns / 1ps

module tb_top;
  import cfe_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [7:0] device_id_i     = 8'h00;
  logic [7:0] command_value_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [7:0] frame_byte_o;
  logic       last_byte_o;

  int          err_count;
  int          pending;
  int          cycle_cnt   = 0;
  int          burst_left  = 0;
  int          mode_cycles = 0;
  stall_mode_e stall_mode  = STALL_NONE;

  command_frame_encoder_crc16_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .device_id_i    (device_id_i),
    .command_value_i(command_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .last_byte_o    (last_byte_o)
  );

  cfe_frame_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .device_id_i    (device_id_i),
    .command_value_i(command_value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_i   (frame_byte_o),
    .last_byte_i    (last_byte_o),
    .err_count_o    (err_count),
    .pending_o      (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: switch between stall patterns at random
  always @(negedge clk_i) begin
    if (mode_cycles == 0) begin
      stall_mode  <= stall_mode_e'($urandom_range(0, 3));
      mode_cycles <= $urandom_range(20, 80);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall_i <= (mode_cycles % 3 == 0);
      default:        out_stall_i <= 1'b0;
    endcase
  end

  // present one command and hold it until the block takes it
  task automatic send_cmd(input logic [7:0] dev, input logic [7:0] val);
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    device_id_i     <= dev;
    command_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  initial begin
    logic [7:0] dev;
    logic [7:0] val;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    pause(2);

    // directed: every device code, unknown ids at both ends, value extremes
    send_cmd(8'd0, 8'h00);
    send_cmd(DEV_VALVE_A, 8'h00);
    send_cmd(DEV_VALVE_B, 8'hFF);
    send_cmd(DEV_VALVE_C, 8'h55);
    send_cmd(DEV_ENGINE, 8'hAA);
    send_cmd(DEV_RESET, 8'h01);
    send_cmd(8'd255, 8'h80);
    send_cmd(8'd6, 8'h7F);
    send_cmd(DEV_VALVE_A, 8'hFF);
    send_cmd(DEV_RESET, 8'hFF);
    send_cmd(DEV_ENGINE, 8'h00);
    send_cmd(8'd128, 8'h12);
    send_cmd(DEV_VALVE_C, 8'h00);
    send_cmd(DEV_VALVE_B, 8'h80);
    send_cmd(8'd0, 8'hFF);
    send_cmd(DEV_RESET, 8'h00);
    pause(5);
    send_cmd(DEV_ENGINE, 8'hFF);
    send_cmd(8'd4 + 8'd250, 8'h3C);

    // random: mostly known devices, a share of arbitrary ids
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
        burst_left = $urandom_range(1, 12);
      end
      if ($urandom_range(0, 3) == 0) dev = 8'($urandom_range(0, 255));
      else dev = 8'($urandom_range(1, 5));
      val = 8'($urandom_range(0, 255));
      send_cmd(dev, val);
      burst_left--;
    end

    pause(1);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
